FILE: hw/rtl/lsqf_pkg.sv
// shared constants, codes and types of the load/store queue
`default_nettype none
package lsqf_pkg;

	localparam int LOAD_DEPTH  = 32;
	localparam int STORE_DEPTH = 32;
	localparam int LD_IW       = $clog2(LOAD_DEPTH);
	localparam int ST_IW       = $clog2(STORE_DEPTH);
	localparam int ID_W        = 32;
	localparam int ADDR_W      = 48;
	localparam int BOB_W       = 4;
	localparam logic [BOB_W-1:0] BOB_RESET = 4'd6;

	localparam logic [2:0] OP_LOAD_DISP  = 3'd0;
	localparam logic [2:0] OP_STORE_DISP = 3'd1;
	localparam logic [2:0] OP_STORE_EXEC = 3'd2;
	localparam logic [2:0] OP_COMMIT     = 3'd3;
	localparam logic [2:0] OP_LOAD_ISSUE = 3'd4;
	localparam logic [2:0] OP_CACHE_RET  = 3'd5;

	localparam logic [3:0] KIND_READY     = 4'd0;
	localparam logic [3:0] KIND_FORWARDED = 4'd1;
	localparam logic [3:0] KIND_WAITS     = 4'd2;
	localparam logic [3:0] KIND_FULL      = 4'd3;
	localparam logic [3:0] KIND_TAKEN     = 4'd4;
	localparam logic [3:0] KIND_RELEASED  = 4'd5;
	localparam logic [3:0] KIND_ISSUED    = 4'd6;
	localparam logic [3:0] KIND_COMPLETED = 4'd7;
	localparam logic [3:0] KIND_COMMITTED = 4'd8;
	localparam logic [3:0] KIND_NONE      = 4'd9;
	localparam logic [3:0] KIND_UNKNOWN   = 4'd10;

	typedef struct packed {
		logic [2:0]        operation;
		logic [ID_W-1:0]   seq_id;
		logic [ADDR_W-1:0] address;
	} lsqf_req_t;

	typedef struct packed {
		logic [3:0]        kind;
		logic [ID_W-1:0]   load_id;
		logic [ADDR_W-1:0] load_address;
		logic [ID_W-1:0]   dep_id;
		logic              last;
	} lsqf_rsp_t;

	typedef struct packed {
		logic capture;
		logic eval;
		logic decide;
		logic find;
		logic fin;
		logic loop;
		logic emit;
	} lsqf_cmd_t;

	typedef struct packed {
		logic dec_find;
		logic dec_loop;
		logic find_more;
		logic loop_last;
	} lsqf_sts_t;

	// lowest set bit of a load-queue vector
	function automatic logic [LD_IW-1:0] ld_first(logic [LOAD_DEPTH-1:0] v);
		logic [LD_IW-1:0] r;
		r = '0;
		for (int i = LOAD_DEPTH - 1; i >= 0; i--) begin
			if (v[i]) r = LD_IW'(i);
		end
		return r;
	endfunction

	// lowest set bit of a store-queue position vector
	function automatic logic [ST_IW-1:0] st_first(logic [STORE_DEPTH-1:0] v);
		logic [ST_IW-1:0] r;
		r = '0;
		for (int i = STORE_DEPTH - 1; i >= 0; i--) begin
			if (v[i]) r = ST_IW'(i);
		end
		return r;
	endfunction

	// slot of the store k positions after the head
	function automatic logic [ST_IW-1:0] st_slot(logic [ST_IW-1:0] head, logic [ST_IW:0] k);
		logic [ST_IW+1:0] sum;
		sum = {2'b00, head} + {1'b0, k};
		if (sum >= (ST_IW+2)'(STORE_DEPTH)) sum = sum - (ST_IW+2)'(STORE_DEPTH);
		return sum[ST_IW-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/lsqf_dp.sv
// load/store queue datapath: queue storage, parallel compares and result register
`default_nettype none
module lsqf_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lsqf_pkg::lsqf_req_t          req,
	input  wire logic                         cfg_we,
	input  wire logic [lsqf_pkg::BOB_W-1:0]   cfg_wdata,
	input  wire lsqf_pkg::lsqf_cmd_t          cmd,
	output lsqf_pkg::lsqf_sts_t               sts,
	output lsqf_pkg::lsqf_rsp_t               rsp
);

	logic [2:0]                      op_q;
	logic [lsqf_pkg::ID_W-1:0]       id_q;
	logic [lsqf_pkg::ADDR_W-1:0]     addr_q;
	logic [lsqf_pkg::BOB_W-1:0]      bob_q;

	logic [lsqf_pkg::ID_W-1:0]       st_id_q   [lsqf_pkg::STORE_DEPTH];
	logic [lsqf_pkg::ADDR_W-1:0]     st_addr_q [lsqf_pkg::STORE_DEPTH];
	logic [lsqf_pkg::STORE_DEPTH-1:0] st_exec_q;
	logic [lsqf_pkg::ST_IW-1:0]      st_head_q;
	logic [lsqf_pkg::ST_IW:0]        st_count_q;

	logic [lsqf_pkg::LOAD_DEPTH-1:0] ld_valid_q, ld_wait_q, ld_iss_q;
	logic [lsqf_pkg::ID_W-1:0]       ld_id_q   [lsqf_pkg::LOAD_DEPTH];
	logic [lsqf_pkg::ADDR_W-1:0]     ld_addr_q [lsqf_pkg::LOAD_DEPTH];
	logic [lsqf_pkg::ID_W-1:0]       ld_prod_q [lsqf_pkg::LOAD_DEPTH];

	logic [lsqf_pkg::STORE_DEPTH-1:0] rem_q, unexec_q;
	logic                             id_any_q;
	logic [lsqf_pkg::LOAD_DEPTH-1:0]  sel_q;
	logic [lsqf_pkg::ST_IW-1:0]       best_slot_q;
	logic [lsqf_pkg::ID_W-1:0]        best_id_q;
	logic                             best_found_q;
	lsqf_pkg::lsqf_rsp_t              rsp_q;

	logic [lsqf_pkg::STORE_DEPTH-1:0] addr_hit_d, id_hit_d, unexec_d;
	logic [lsqf_pkg::LOAD_DEPTH-1:0]  ld_rel_d, ld_cmp_d;
	logic [lsqf_pkg::ADDR_W-1:0]      blk_mask;

	// parallel compare over both queues, store side in age order from the head
	always_comb begin
		logic [lsqf_pkg::ST_IW-1:0] s;
		logic inq;
		blk_mask = {lsqf_pkg::ADDR_W{1'b1}} << bob_q;
		for (int k = 0; k < lsqf_pkg::STORE_DEPTH; k++) begin
			s = lsqf_pkg::st_slot(st_head_q, (lsqf_pkg::ST_IW+1)'(k));
			inq = (lsqf_pkg::ST_IW+1)'(k) < st_count_q;
			addr_hit_d[k] = inq && (st_addr_q[s] == addr_q);
			id_hit_d[k]   = inq && (st_id_q[s] == id_q);
			unexec_d[k]   = id_hit_d[k] && !st_exec_q[s];
		end
		for (int i = 0; i < lsqf_pkg::LOAD_DEPTH; i++) begin
			ld_rel_d[i] = ld_valid_q[i] && ld_wait_q[i] && (ld_prod_q[i] == id_q);
			ld_cmp_d[i] = ld_valid_q[i] && ld_iss_q[i]
				&& (((ld_addr_q[i] ^ addr_q) & blk_mask) == '0);
		end
	end

	logic [lsqf_pkg::LOAD_DEPTH-1:0] free_vec, ready_vec;
	logic                            free_any, ready_any;
	logic [lsqf_pkg::LD_IW-1:0]      free_idx, ready_idx, loop_idx, ld_rd_idx;
	logic [lsqf_pkg::ST_IW-1:0]      ex_slot, find_pos, find_slot, st_rd_slot, new_slot;
	logic [lsqf_pkg::ID_W-1:0]       rd_id;
	logic [lsqf_pkg::ADDR_W-1:0]     rd_addr;
	logic                            commit_ok, store_room, exec_hit, forwarded;

	assign free_vec   = ~ld_valid_q;
	assign free_any   = |free_vec;
	assign free_idx   = lsqf_pkg::ld_first(free_vec);
	assign ready_vec  = ld_valid_q & ~ld_wait_q & ~ld_iss_q;
	assign ready_any  = |ready_vec;
	assign ready_idx  = lsqf_pkg::ld_first(ready_vec);
	assign loop_idx   = lsqf_pkg::ld_first(sel_q);
	assign ld_rd_idx  = (op_q == lsqf_pkg::OP_LOAD_ISSUE) ? ready_idx : loop_idx;

	assign ex_slot    = lsqf_pkg::st_slot(st_head_q,
		{1'b0, lsqf_pkg::st_first(unexec_q)});
	assign find_pos   = lsqf_pkg::st_first(rem_q);
	assign find_slot  = lsqf_pkg::st_slot(st_head_q, {1'b0, find_pos});
	assign st_rd_slot = (op_q == lsqf_pkg::OP_COMMIT) ? st_head_q : find_slot;
	assign rd_id      = st_id_q[st_rd_slot];
	assign rd_addr    = st_addr_q[st_rd_slot];
	assign new_slot   = lsqf_pkg::st_slot(st_head_q, st_count_q);
	assign store_room = st_count_q < (lsqf_pkg::ST_IW+1)'(lsqf_pkg::STORE_DEPTH);
	assign commit_ok  = (st_count_q != '0) && st_exec_q[st_head_q] && (rd_id < id_q);
	assign exec_hit   = id_any_q && (|unexec_q);
	assign forwarded  = best_found_q && st_exec_q[best_slot_q];

	assign sts.dec_find  = (op_q == lsqf_pkg::OP_LOAD_DISP) && free_any;
	assign sts.dec_loop  = ((op_q == lsqf_pkg::OP_STORE_EXEC) && exec_hit)
		|| (op_q == lsqf_pkg::OP_CACHE_RET);
	assign sts.find_more = |rem_q;
	assign sts.loop_last = (sel_q & (sel_q - 1'b1)) == '0;

	lsqf_pkg::lsqf_rsp_t res_d;

	always_comb begin
		res_d = '{kind: lsqf_pkg::KIND_NONE, load_id: '0, load_address: '0,
			dep_id: '0, last: 1'b1};
		if (cmd.fin) begin
			res_d.load_id      = id_q;
			res_d.load_address = addr_q;
			if (forwarded) begin
				res_d.kind = lsqf_pkg::KIND_FORWARDED;
			end else if (best_found_q) begin
				res_d.kind   = lsqf_pkg::KIND_WAITS;
				res_d.dep_id = best_id_q;
			end else begin
				res_d.kind = lsqf_pkg::KIND_READY;
			end
		end else if (cmd.loop) begin
			if (|sel_q) begin
				res_d.kind         = (op_q == lsqf_pkg::OP_STORE_EXEC)
					? lsqf_pkg::KIND_RELEASED : lsqf_pkg::KIND_COMPLETED;
				res_d.load_id      = ld_id_q[ld_rd_idx];
				res_d.load_address = ld_addr_q[ld_rd_idx];
				res_d.dep_id       = (op_q == lsqf_pkg::OP_STORE_EXEC) ? id_q : '0;
				res_d.last         = sts.loop_last;
			end
		end else begin
			case (op_q)
				lsqf_pkg::OP_LOAD_DISP, lsqf_pkg::OP_STORE_DISP: begin
					res_d.kind = (op_q == lsqf_pkg::OP_STORE_DISP && store_room)
						? lsqf_pkg::KIND_TAKEN : lsqf_pkg::KIND_FULL;
					res_d.load_id      = id_q;
					res_d.load_address = addr_q;
				end
				lsqf_pkg::OP_STORE_EXEC: begin
					if (!id_any_q) begin
						res_d.kind         = lsqf_pkg::KIND_UNKNOWN;
						res_d.load_id      = id_q;
						res_d.load_address = addr_q;
					end
				end
				lsqf_pkg::OP_COMMIT: begin
					if (commit_ok) begin
						res_d.kind         = lsqf_pkg::KIND_COMMITTED;
						res_d.load_id      = rd_id;
						res_d.load_address = rd_addr;
					end
				end
				lsqf_pkg::OP_LOAD_ISSUE: begin
					if (ready_any) begin
						res_d.kind         = lsqf_pkg::KIND_ISSUED;
						res_d.load_id      = ld_id_q[ld_rd_idx];
						res_d.load_address = ld_addr_q[ld_rd_idx];
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bob_q      <= lsqf_pkg::BOB_RESET;
			st_exec_q  <= '0;
			st_head_q  <= '0;
			st_count_q <= '0;
			ld_valid_q <= '0;
			ld_wait_q  <= '0;
			ld_iss_q   <= '0;
		end else begin
			if (cfg_we) bob_q <= cfg_wdata;
			if (cmd.decide) begin
				case (op_q)
					lsqf_pkg::OP_STORE_DISP: begin
						if (store_room) begin
							st_exec_q[new_slot] <= 1'b0;
							st_count_q          <= st_count_q + 1'b1;
						end
					end
					lsqf_pkg::OP_STORE_EXEC: begin
						if (exec_hit) st_exec_q[ex_slot] <= 1'b1;
					end
					lsqf_pkg::OP_COMMIT: begin
						if (commit_ok) begin
							st_exec_q[st_head_q] <= 1'b0;
							st_head_q  <= lsqf_pkg::st_slot(st_head_q, (lsqf_pkg::ST_IW+1)'(1));
							st_count_q <= st_count_q - 1'b1;
						end
					end
					lsqf_pkg::OP_LOAD_ISSUE: begin
						if (ready_any) ld_iss_q[ready_idx] <= 1'b1;
					end
					default: ;
				endcase
			end
			if (cmd.fin && !forwarded) begin
				ld_valid_q[free_idx] <= 1'b1;
				ld_wait_q[free_idx]  <= best_found_q;
				ld_iss_q[free_idx]   <= 1'b0;
			end
			if (cmd.loop && (|sel_q)) begin
				ld_valid_q[loop_idx] <= 1'b0;
				ld_wait_q[loop_idx]  <= 1'b0;
				ld_iss_q[loop_idx]   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= req.operation;
			id_q   <= req.seq_id;
			addr_q <= req.address;
		end
		if (cmd.eval) begin
			rem_q        <= addr_hit_d;
			unexec_q     <= unexec_d;
			id_any_q     <= |id_hit_d;
			sel_q        <= (op_q == lsqf_pkg::OP_STORE_EXEC) ? ld_rel_d : ld_cmp_d;
			best_found_q <= 1'b0;
		end
		if (cmd.decide && (op_q == lsqf_pkg::OP_STORE_DISP) && store_room) begin
			st_id_q[new_slot]   <= id_q;
			st_addr_q[new_slot] <= addr_q;
		end
		// youngest store wins, ties keep the one nearer the head
		if (cmd.find && (|rem_q)) begin
			rem_q[find_pos] <= 1'b0;
			if (!best_found_q || (rd_id > best_id_q)) begin
				best_found_q <= 1'b1;
				best_slot_q  <= find_slot;
				best_id_q    <= rd_id;
			end
		end
		if (cmd.fin && !forwarded) begin
			ld_id_q[free_idx]   <= id_q;
			ld_addr_q[free_idx] <= addr_q;
			ld_prod_q[free_idx] <= best_found_q ? best_id_q : '0;
		end
		if (cmd.loop && (|sel_q)) sel_q[loop_idx] <= 1'b0;
		if (cmd.emit) rsp_q <= res_d;
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_count_q <= (lsqf_pkg::ST_IW+1)'(lsqf_pkg::STORE_DEPTH))
		else $error("store count above depth");

	a_wait_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_wait_q & ~ld_valid_q) == '0)
		else $error("waiting load in a free slot");

	a_issue_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(ld_iss_q & (~ld_valid_q | ld_wait_q)) == '0)
		else $error("issued load is free or waiting");

endmodule
`default_nettype wire

FILE: hw/rtl/lsqf_ctrl.sv
// load/store queue controller: request sequencing and result handshake
`default_nettype none
module lsqf_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_stall,
	output logic                      rsp_valid,
	input  wire logic                 rsp_stall,
	input  wire lsqf_pkg::lsqf_sts_t  sts,
	output lsqf_pkg::lsqf_cmd_t       cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EVAL   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_FIND   = 3'd3;
	localparam logic [2:0] S_FIN    = 3'd4;
	localparam logic [2:0] S_LOOP   = 3'd5;

	logic [2:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;

	assign req_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	// result register may be refilled once the waiting result is taken
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.capture = req_valid;
				if (req_valid) state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = S_DECIDE;
			end
			S_DECIDE: begin
				if (out_free) begin
					cmd.decide = 1'b1;
					cmd.emit   = !sts.dec_find && !sts.dec_loop;
					state_d    = sts.dec_find ? S_FIND : (sts.dec_loop ? S_LOOP : S_IDLE);
				end
			end
			S_FIND: begin
				cmd.find = sts.find_more;
				if (!sts.find_more) state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.fin  = 1'b1;
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_LOOP: begin
				if (out_free) begin
					cmd.loop = 1'b1;
					cmd.emit = 1'b1;
					if (sts.loop_last) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_EVAL))
		else $error("accepted request not evaluated");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> !$past(cmd.emit))
		else $error("result overwritten while stalled");

	a_find_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIND) |-> !cmd.emit)
		else $error("result during store search");

endmodule
`default_nettype wire

FILE: hw/rtl/load_store_queue_forwarding.sv
// load/store queue with store-to-load forwarding, top level
// One request is worked at a time: it is accepted, compared against all store and load
// entries in parallel in the next cycle, and decided once the output register is free. A
// load dispatch first searches the store entries with the same address for the youngest
// store (reading one store id per cycle); a store execute or cache return gives one result
// per cycle while the output is not stalled, one for each load it frees. A new request can
// be accepted while the last result still waits in the output register.
`default_nettype none
module load_store_queue_forwarding (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire lsqf_pkg::lsqf_req_t         req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output lsqf_pkg::lsqf_rsp_t              rsp,
	input  wire logic                        cfg_we,
	input  wire logic [lsqf_pkg::BOB_W-1:0]  cfg_wdata
);

	lsqf_pkg::lsqf_cmd_t cmd;
	lsqf_pkg::lsqf_sts_t sts;

	lsqf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	lsqf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
